// ----- rtl/core/scre_pkg.sv -----
// Shared types and constants for the serial command/response engine.
// Depends on nothing; used by the cells and the top level.
package scre_pkg;

  localparam int unsigned WIN_LEN   = 7;
  localparam int unsigned FRAME_LEN = 5;

  localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [31:0] TIMEOUT_DATA  = 32'hFFFF_FFFF;

  // Input item kinds
  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_RX    = 2'd1,
    FUNC_TICK  = 2'd2
  } func_t;

  // Result item kinds
  typedef enum logic [1:0] {
    KIND_TX      = 2'd0,
    KIND_RESP    = 2'd1,
    KIND_TIMEOUT = 2'd2
  } kind_t;

  // Transaction phase
  typedef enum logic {
    PHASE_IDLE = 1'b0,
    PHASE_BUSY = 1'b1
  } phase_t;

  // Per-cycle control for a row of cells
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

// ----- rtl/core/scre_win_cell.sv -----
// One byte cell of the receive window chain.
// Depends on scre_pkg for the cell control struct.
module scre_win_cell (
  input  logic                clk,
  input  logic                rst,
  input  scre_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]          byte_in,
  input  logic                valid_in,
  output logic [7:0]          byte_q,
  output logic                valid_q
);

  // Drop the contents on load, take the neighbor's byte on shift
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (ctrl.load) begin
      valid_q <= 1'b0;
    end else if (ctrl.shift) begin
      valid_q <= valid_in;
    end
  end

  // Advance the payload byte
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      byte_q <= byte_in;
    end
  end

endmodule

// ----- rtl/core/scre_tx_cell.sv -----
// One beat cell of the transmit frame chain.
// Depends on scre_pkg for the cell control struct.
module scre_tx_cell (
  input  logic                clk,
  input  logic                rst,
  input  scre_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]          load_byte,
  input  logic                load_last,
  input  logic [7:0]          next_byte,
  input  logic                next_last,
  input  logic                next_valid,
  output logic [7:0]          byte_q,
  output logic                last_q,
  output logic                valid_q
);

  // Fill on load, hand toward the output on shift
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (ctrl.load) begin
      valid_q <= 1'b1;
    end else if (ctrl.shift) begin
      valid_q <= next_valid;
    end
  end

  // Payload follows the same choice
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      byte_q <= load_byte;
      last_q <= load_last;
    end else if (ctrl.shift) begin
      byte_q <= next_byte;
      last_q <= next_last;
    end
  end

endmodule

// ----- rtl/core/serial_command_response_engine_core.sv -----
// Latency: a start shows its first frame beat the cycle after acceptance, one per out_ready cycle.
// A response or timeout result shows the cycle after its byte or tick, behind any frame beats.
// Throughput: one item per cycle; in_ready drops only while a response/timeout beat waits
// in the single result register. Frame beats leave a five-cell chain, one per out_ready cycle.
// Reset (rst, synchronous): idle, empty window and frame chain, timeout register = 1000.
// Top level; uses scre_pkg, scre_win_cell and scre_tx_cell.
module serial_command_response_engine_core (
  input  logic               clk,
  input  logic               rst,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic [7:0]         command_id,
  input  logic [7:0]         data_first,
  input  logic [7:0]         data_second,
  input  logic [7:0]         rx_byte,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [7:0]         tx_byte,
  output logic signed [31:0] response_data,
  output logic               last
);

  localparam int unsigned WL = scre_pkg::WIN_LEN;
  localparam int unsigned FL = scre_pkg::FRAME_LEN;

  scre_pkg::phase_t     phase, phase_next;
  scre_pkg::cell_ctrl_t win_ctrl, tx_ctrl;

  logic [15:0] timeout_ticks;
  logic [15:0] timeout_left;
  logic [7:0]  sent_command;

  logic [7:0] win_byte [WL];
  logic [WL-1:0] win_valid;

  logic [7:0] tx_cell_byte [FL];
  logic [FL-1:0] tx_cell_last;
  logic [FL-1:0] tx_valid;
  logic [7:0] frame_byte [FL];

  logic        res_valid;
  logic [1:0]  res_kind;
  logic [31:0] res_data;

  logic in_fire, out_fire;
  logic start_go, rx_go, tick_go;
  logic rx_match, timeout_hit, res_set, res_take;
  logic [7:0] win_xor;

  // Configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= scre_pkg::TIMEOUT_RESET;
    end else if (cfg_valid) begin
      timeout_ticks <= cfg_data;
    end
  end

  // Handshakes
  assign in_fire  = in_valid & in_ready;
  assign out_fire = out_valid & out_ready;
  assign res_take = out_fire & ~tx_valid[0];
  assign in_ready = ~res_valid | (out_ready & ~tx_valid[0]);

  // Match on the window as it stands after this byte shifts in
  assign win_xor  = win_byte[1] ^ win_byte[2] ^ win_byte[3]
                  ^ win_byte[4] ^ win_byte[5] ^ win_byte[6];
  assign rx_match = (&win_valid[WL-1:1]) && (win_byte[1] == scre_pkg::SYNC_BYTE)
                    && (win_byte[2] == sent_command) && (rx_byte == win_xor);
  assign timeout_hit = (timeout_left <= 16'd1);

  // Decode the accepted beat
  always_comb begin
    start_go = 1'b0;
    rx_go    = 1'b0;
    tick_go  = 1'b0;
    if (in_fire) begin
      case (scre_pkg::func_t'(func))
        scre_pkg::FUNC_START: start_go = (phase == scre_pkg::PHASE_IDLE);
        scre_pkg::FUNC_RX:    rx_go    = (phase == scre_pkg::PHASE_BUSY);
        scre_pkg::FUNC_TICK:  tick_go  = (phase == scre_pkg::PHASE_BUSY);
        default: ;
      endcase
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      scre_pkg::PHASE_IDLE: begin
        if (start_go) phase_next = scre_pkg::PHASE_BUSY;
      end
      scre_pkg::PHASE_BUSY: begin
        if ((rx_go && rx_match) || (tick_go && timeout_hit)) begin
          phase_next = scre_pkg::PHASE_IDLE;
        end
      end
      default: phase_next = scre_pkg::PHASE_IDLE;
    endcase
  end

  // Phase outputs: chain control and result capture
  always_comb begin
    win_ctrl.load  = start_go;
    win_ctrl.shift = rx_go;
    tx_ctrl.load   = start_go;
    tx_ctrl.shift  = out_fire & tx_valid[0];
    res_set        = 1'b0;
    case (phase)
      scre_pkg::PHASE_BUSY: res_set = (rx_go && rx_match) || (tick_go && timeout_hit);
      default:              res_set = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= scre_pkg::PHASE_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  // Transaction registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sent_command <= '0;
      timeout_left <= '0;
    end else if (start_go) begin
      sent_command <= command_id;
      timeout_left <= timeout_ticks;
    end else if (tick_go) begin
      timeout_left <= timeout_hit ? 16'd0 : timeout_left - 16'd1;
    end
  end

  // Hold one response or timeout beat
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_set) begin
      res_valid <= 1'b1;
    end else if (res_take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_set) begin
      if (rx_go) begin
        res_kind <= scre_pkg::KIND_RESP;
        res_data <= {win_byte[6], win_byte[5], win_byte[4], win_byte[3]};
      end else begin
        res_kind <= scre_pkg::KIND_TIMEOUT;
        res_data <= scre_pkg::TIMEOUT_DATA;
      end
    end
  end

  // Receive window: newest byte enters the top cell, older bytes move down
  for (genvar i = 0; i < WL; i++) begin : g_win
    logic [7:0] nb;
    logic       nv;
    if (i == WL - 1) begin : g_top
      assign nb = rx_byte;
      assign nv = 1'b1;
    end else begin : g_mid
      assign nb = win_byte[i+1];
      assign nv = win_valid[i+1];
    end
    scre_win_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (win_ctrl),
      .byte_in  (nb),
      .valid_in (nv),
      .byte_q   (win_byte[i]),
      .valid_q  (win_valid[i])
    );
  end

  // Frame contents
  assign frame_byte[0] = scre_pkg::SYNC_BYTE;
  assign frame_byte[1] = command_id;
  assign frame_byte[2] = data_first;
  assign frame_byte[3] = data_second;
  assign frame_byte[4] = scre_pkg::SYNC_BYTE ^ command_id ^ data_first ^ data_second;

  // Transmit chain: head cell faces the output
  for (genvar j = 0; j < FL; j++) begin : g_tx
    logic [7:0] nb;
    logic       nl;
    logic       nv;
    if (j == FL - 1) begin : g_top
      assign nb = '0;
      assign nl = 1'b0;
      assign nv = 1'b0;
    end else begin : g_mid
      assign nb = tx_cell_byte[j+1];
      assign nl = tx_cell_last[j+1];
      assign nv = tx_valid[j+1];
    end
    scre_tx_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (tx_ctrl),
      .load_byte  (frame_byte[j]),
      .load_last  (j == FL - 1),
      .next_byte  (nb),
      .next_last  (nl),
      .next_valid (nv),
      .byte_q     (tx_cell_byte[j]),
      .last_q     (tx_cell_last[j]),
      .valid_q    (tx_valid[j])
    );
  end

  // Output mux: frame beats go ahead of the held result
  assign out_valid = tx_valid[0] | res_valid;
  always_comb begin
    if (tx_valid[0]) begin
      kind          = scre_pkg::KIND_TX;
      tx_byte       = tx_cell_byte[0];
      response_data = '0;
      last          = tx_cell_last[0];
    end else begin
      kind          = res_kind;
      tx_byte       = '0;
      response_data = res_data;
      last          = 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_start_chain_empty: assert property (@(posedge clk) disable iff (rst)
    start_go |-> !tx_valid[0])
    else $error("start loaded while frame beats still pending");

  a_result_while_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> phase == scre_pkg::PHASE_IDLE)
    else $error("result pending while transaction still busy");

  a_last_is_final_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> tx_valid[0] && !tx_valid[1])
    else $error("last flag on a beat that is not the final frame beat");

  a_window_fills_from_top: assert property (@(posedge clk) disable iff (rst)
    win_valid[0] |-> win_valid[WL-1])
    else $error("window valid bits not contiguous");
`endif

endmodule
